@@ hdl/tobb_pkg.sv @@
// Shared constants and types for the triangle versus oriented box overlap test.
package tobb_pkg;

   localparam int COORD_BITS_DEF     = 16;
   localparam int AXIS_FRAC_BITS_DEF = 14;
   localparam int CSR_DATA_W         = 64;
   localparam int CSR_ADDR_W         = 6;
   localparam int REG_W              = 48;
   localparam int TOL_W              = 16;
   localparam int QUEUE_DEPTH        = 4;
   localparam int AXIS_CODE_W        = 4;
   localparam int NUM_TESTS          = 13;

   localparam logic [AXIS_CODE_W-1:0] AXIS_NONE  = 4'd0;
   localparam logic [AXIS_CODE_W-1:0] AXIS_PLANE = 4'd13;

   typedef enum logic [2:0] {
      REG_CENTER      = 3'd0,
      REG_AXIS_FIRST  = 3'd1,
      REG_AXIS_SECOND = 3'd2,
      REG_AXIS_THIRD  = 3'd3,
      REG_HALF        = 3'd4,
      REG_TOL         = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

@@ hdl/tobb_front.sv @@
// Input stage: takes a triangle word and moves its vertices relative to the box center.
module tobb_front #(
   parameter int COORD_BITS = tobb_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [9*COORD_BITS-1:0]       req_data,
   input  logic [tobb_pkg::REG_W-1:0]    box_center,
   input  tobb_pkg::queue_stat_type      queue_stat,
   output logic                          out_valid,
   output logic [9*(COORD_BITS+1)-1:0]   out_data
);
   localparam int PW = COORD_BITS + 1;

   logic                        valid_ff, valid_in;
   logic [9*PW-1:0]             data_ff, data_in;
   logic [3*COORD_BITS+tobb_pkg::REG_W-1:0] ctr_ext;

   assign req_tready = !valid_ff || !queue_stat.full;
   assign out_valid  = valid_ff;
   assign out_data   = data_ff;
   assign ctr_ext    = {{(3*COORD_BITS){1'b0}}, box_center};

   always_comb begin
      logic signed [PW-1:0] c;
      logic signed [PW-1:0] m;
      valid_in = req_tready ? req_tvalid : valid_ff;
      data_in  = data_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            c = $signed(req_data[(i*3+j)*COORD_BITS +: COORD_BITS]);
            m = $signed(ctr_ext[j*COORD_BITS +: COORD_BITS]);
            data_in[(i*3+j)*PW +: PW] = c - m;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/tobb_fifo.sv @@
// Short word queue between the input stage and the test pipeline.
module tobb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tobb_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output tobb_pkg::queue_stat_type stat
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign stat.full  = (cnt_ff == CNT_W'(DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_data   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? PTR_W'(wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? PTR_W'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/tobb_back.sv @@
// Test pipeline: box frame transform, thirteen separating-axis tests, result register.
module tobb_back #(
   parameter int COORD_BITS     = tobb_pkg::COORD_BITS_DEF,
   parameter int AXIS_FRAC_BITS = tobb_pkg::AXIS_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_pop,
   input  logic [9*(COORD_BITS+1)-1:0]         in_data,
   input  logic [tobb_pkg::REG_W-1:0]          axis_first,
   input  logic [tobb_pkg::REG_W-1:0]          axis_second,
   input  logic [tobb_pkg::REG_W-1:0]          axis_third,
   input  logic [tobb_pkg::REG_W-1:0]          half_extents,
   input  logic [tobb_pkg::TOL_W-1:0]          tolerance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                overlaps,
   output logic [tobb_pkg::AXIS_CODE_W-1:0]    separating_axis
);
   localparam int CB  = COORD_BITS;
   localparam int PW  = CB + 1;
   localparam int AB  = AXIS_FRAC_BITS + 2;
   localparam int MW  = PW + AB;
   localparam int SW  = MW + 2;
   localparam int VW  = SW - AXIS_FRAC_BITS;
   localparam int EW  = VW + 1;
   localparam int XW  = EW + VW + 1;
   localparam int RW  = EW + CB + 1;
   localparam int CW  = XW + 2;
   localparam int FW  = ((VW > tobb_pkg::TOL_W + 2) ? VW : tobb_pkg::TOL_W + 2) + 2;
   localparam int NW  = 2*EW + 1;
   localparam int HW  = CB + 1;
   localparam int LW  = EW + 1 + VW;
   localparam int KW  = EW + 1 + HW;
   localparam int TW  = NW + VW + 4;
   localparam int NST = 8;
   localparam int RX  = tobb_pkg::REG_W;
   localparam int TOLW = tobb_pkg::TOL_W;

   logic en;
   logic [NST-1:0] vld_ff, vld_in;
   logic           out_vld_ff;

   logic [3*AB+RX-1:0] axe [3];
   logic [3*CB+RX-1:0] hext;
   logic [CB-1:0]      h [3];

   logic signed [MW-1:0]   prod_ff [3][3][3];
   logic signed [MW-1:0]   prod_in [3][3][3];
   logic signed [VW-1:0]   v2_ff [3][3];
   logic signed [VW-1:0]   v2_in [3][3];
   logic signed [VW-1:0]   v3_ff [3][3];
   logic signed [EW-1:0]   e3_ff [3][3];
   logic signed [EW-1:0]   e3_in [3][3];
   logic [EW-1:0]          ae3_ff [3][3];
   logic [EW-1:0]          ae3_in [3][3];
   logic signed [EW-1:0]   b3_ff [3];
   logic signed [EW-1:0]   b3_in [3];
   logic [2:0]             face3_ff, face3_in;
   logic signed [XW-2:0]   ma4_ff [3][3][2];
   logic signed [XW-2:0]   ma4_in [3][3][2];
   logic signed [XW-2:0]   mb4_ff [3][3][2];
   logic signed [XW-2:0]   mb4_in [3][3][2];
   logic [RW-2:0]          ra4_ff [3][3];
   logic [RW-2:0]          ra4_in [3][3];
   logic [RW-2:0]          rb4_ff [3][3];
   logic [RW-2:0]          rb4_in [3][3];
   logic signed [2*EW-1:0] na4_ff [3];
   logic signed [2*EW-1:0] na4_in [3];
   logic signed [2*EW-1:0] nb4_ff [3];
   logic signed [2*EW-1:0] nb4_in [3];
   logic signed [VW-1:0]   v04_ff [3];
   logic [2:0]             face4_ff;
   logic signed [NW-1:0]   n5_ff [3];
   logic signed [NW-1:0]   n5_in [3];
   logic signed [VW-1:0]   v05_ff [3];
   logic [8:0]             edge5_ff, edge5_in;
   logic [2:0]             face5_ff;
   logic signed [LW-1:0]   nvl6_ff [3], nvl6_in [3], nvh6_ff [3], nvh6_in [3];
   logic signed [KW-1:0]   nhl6_ff [3], nhl6_in [3], nhh6_ff [3], nhh6_in [3];
   logic [2:0]             pos6_ff, pos6_in;
   logic [8:0]             edge6_ff;
   logic [2:0]             face6_ff;
   logic signed [TW-1:0]   nv7_ff [3], nv7_in [3], nh7_ff [3], nh7_in [3];
   logic [2:0]             pos7_ff;
   logic [8:0]             edge7_ff;
   logic [2:0]             face7_ff;
   logic signed [TW-1:0]   d8_ff, d8_in, st8_ff, st8_in;
   logic [8:0]             edge8_ff;
   logic [2:0]             face8_ff;
   logic                   ovl_ff, ovl_in;
   logic [tobb_pkg::AXIS_CODE_W-1:0] code_ff, code_in;

   assign en        = !out_vld_ff || rsp_ready;
   assign in_pop    = en && in_valid;
   assign vld_in    = {vld_ff[NST-2:0], in_valid};
   assign rsp_valid = out_vld_ff;
   assign overlaps  = ovl_ff;
   assign separating_axis = code_ff;

   assign axe[0] = {{(3*AB){1'b0}}, axis_first};
   assign axe[1] = {{(3*AB){1'b0}}, axis_second};
   assign axe[2] = {{(3*AB){1'b0}}, axis_third};
   assign hext   = {{(3*CB){1'b0}}, half_extents};
   assign h[0]   = hext[0 +: CB];
   assign h[1]   = hext[CB +: CB];
   assign h[2]   = hext[2*CB +: CB];

   // frame transform products
   always_comb begin
      logic signed [PW-1:0] p;
      logic signed [AB-1:0] a;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               p = $signed(in_data[(i*3+j)*PW +: PW]);
               a = $signed(axe[k][j*AB +: AB]);
               prod_in[i][k][j] = p * a;
            end
         end
      end
   end

   // sum and floor shift
   always_comb begin
      logic signed [SW-1:0] s;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            s = prod_ff[i][k][0];
            s = s + prod_ff[i][k][1];
            s = s + prod_ff[i][k][2];
            v2_in[i][k] = s[SW-1:AXIS_FRAC_BITS];
         end
      end
   end

   // edges and face tests
   always_comb begin
      logic signed [EW-1:0] e;
      logic signed [VW-1:0] mn, mx;
      logic signed [FW-1:0] mnw, mxw, hw, tw;
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            e = v2_ff[(k+1)%3][j];
            e = e - v2_ff[k][j];
            e3_in[k][j]  = e;
            ae3_in[k][j] = e[EW-1] ? EW'(-e) : EW'(e);
         end
      end
      for (int j = 0; j < 3; j++) begin
         e = v2_ff[2][j];
         b3_in[j] = e - v2_ff[0][j];
         mn = v2_ff[0][j];
         mx = v2_ff[0][j];
         for (int i = 1; i < 3; i++) begin
            if (v2_ff[i][j] < mn) begin
               mn = v2_ff[i][j];
            end
            if (v2_ff[i][j] > mx) begin
               mx = v2_ff[i][j];
            end
         end
         mnw = mn;
         mxw = mx;
         hw  = $signed({1'b0, h[j]});
         tw  = $signed({1'b0, tolerance});
         face3_in[j] = (mnw > hw + tw) || (mxw < -hw - tw);
      end
   end

   // edge-axis and normal products
   always_comb begin
      int u, w, pr;
      for (int k = 0; k < 3; k++) begin
         pr = (k + 2) % 3;
         for (int t = 0; t < 3; t++) begin
            u = (t + 1) % 3;
            w = (t + 2) % 3;
            ma4_in[k][t][0] = e3_ff[k][w] * v3_ff[k][u];
            ma4_in[k][t][1] = e3_ff[k][w] * v3_ff[pr][u];
            mb4_in[k][t][0] = e3_ff[k][u] * v3_ff[k][w];
            mb4_in[k][t][1] = e3_ff[k][u] * v3_ff[pr][w];
            ra4_in[k][t]    = ae3_ff[k][w] * h[u];
            rb4_in[k][t]    = ae3_ff[k][u] * h[w];
         end
      end
      for (int j = 0; j < 3; j++) begin
         u = (j + 1) % 3;
         w = (j + 2) % 3;
         na4_in[j] = e3_ff[0][u] * b3_ff[w];
         nb4_in[j] = e3_ff[0][w] * b3_ff[u];
      end
   end

   // edge-axis interval tests, plane normal
   always_comb begin
      logic signed [XW-1:0] p0, p1;
      logic signed [CW-1:0] mnw, mxw, rw, tw;
      logic [RW-1:0]        r;
      for (int k = 0; k < 3; k++) begin
         for (int t = 0; t < 3; t++) begin
            p0 = mb4_ff[k][t][0];
            p0 = p0 - ma4_ff[k][t][0];
            p1 = mb4_ff[k][t][1];
            p1 = p1 - ma4_ff[k][t][1];
            r  = RW'(ra4_ff[k][t]) + RW'(rb4_ff[k][t]);
            mnw = (p0 < p1) ? CW'(p0) : CW'(p1);
            mxw = (p0 < p1) ? CW'(p1) : CW'(p0);
            rw  = $signed({1'b0, r});
            tw  = $signed({1'b0, tolerance});
            edge5_in[k*3+t] = (mxw < -rw - tw) || (mnw > rw + tw);
         end
      end
      for (int j = 0; j < 3; j++) begin
         n5_in[j] = na4_ff[j];
         n5_in[j] = n5_in[j] - nb4_ff[j];
      end
   end

   // plane partial products
   always_comb begin
      logic signed [NW-1:0] tw;
      logic signed [EW:0]   hi;
      logic signed [EW:0]   lo;
      logic signed [HW-1:0] hs;
      tw = $signed({1'b0, tolerance});
      for (int j = 0; j < 3; j++) begin
         pos6_in[j] = n5_ff[j] > tw;
         hi = n5_ff[j][NW-1:EW];
         lo = $signed({1'b0, n5_ff[j][EW-1:0]});
         hs = $signed({1'b0, h[j]});
         nvl6_in[j] = lo * v05_ff[j];
         nvh6_in[j] = hi * v05_ff[j];
         nhl6_in[j] = lo * hs;
         nhh6_in[j] = hi * hs;
      end
   end

   always_comb begin
      logic signed [TW-1:0] a;
      for (int j = 0; j < 3; j++) begin
         a = nvh6_ff[j];
         a = a <<< EW;
         nv7_in[j] = a + nvl6_ff[j];
         a = nhh6_ff[j];
         a = a <<< EW;
         nh7_in[j] = a + nhl6_ff[j];
      end
   end

   always_comb begin
      logic signed [TW-1:0] s;
      s = nv7_ff[0] + nv7_ff[1] + nv7_ff[2];
      d8_in  = -s;
      st8_in = '0;
      for (int j = 0; j < 3; j++) begin
         st8_in = pos7_ff[j] ? st8_in + nh7_ff[j] : st8_in - nh7_ff[j];
      end
   end

   always_comb begin
      logic signed [TW-1:0] tmin, tmax, tw;
      logic [tobb_pkg::NUM_TESTS-1:0] hits;
      tw   = $signed({1'b0, tolerance});
      tmin = d8_ff - st8_ff;
      tmax = d8_ff + st8_ff;
      hits = {(tmin > tw) || (tmax < -tw), face8_ff, edge8_ff};
      code_in = tobb_pkg::AXIS_NONE;
      for (int i = tobb_pkg::NUM_TESTS - 1; i >= 0; i--) begin
         if (hits[i]) begin
            code_in = tobb_pkg::AXIS_CODE_W'(i + 1);
         end
      end
      ovl_in = (code_in == tobb_pkg::AXIS_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         v2_ff    <= v2_in;
         v3_ff    <= v2_ff;
         e3_ff    <= e3_in;
         ae3_ff   <= ae3_in;
         b3_ff    <= b3_in;
         face3_ff <= face3_in;
         ma4_ff   <= ma4_in;
         mb4_ff   <= mb4_in;
         ra4_ff   <= ra4_in;
         rb4_ff   <= rb4_in;
         na4_ff   <= na4_in;
         nb4_ff   <= nb4_in;
         v04_ff   <= v3_ff[0];
         face4_ff <= face3_ff;
         n5_ff    <= n5_in;
         v05_ff   <= v04_ff;
         edge5_ff <= edge5_in;
         face5_ff <= face4_ff;
         nvl6_ff  <= nvl6_in;
         nvh6_ff  <= nvh6_in;
         nhl6_ff  <= nhl6_in;
         nhh6_ff  <= nhh6_in;
         pos6_ff  <= pos6_in;
         edge6_ff <= edge5_ff;
         face6_ff <= face5_ff;
         nv7_ff   <= nv7_in;
         nh7_ff   <= nh7_in;
         pos7_ff  <= pos6_ff;
         edge7_ff <= edge6_ff;
         face7_ff <= face6_ff;
         d8_ff    <= d8_in;
         st8_ff   <= st8_in;
         edge8_ff <= edge7_ff;
         face8_ff <= face7_ff;
         ovl_ff   <= ovl_in;
         code_ff  <= code_in;
      end
   end

endmodule

@@ hdl/triangle_obb_overlap_test.sv @@
// Top level: register port, input stage, queue and test pipeline.
// One triangle word is accepted per clock and one result word leaves per clock while the
// result channel takes words and the queue has room; a word passes the input stage register,
// then the four-entry queue, then the nine pipeline registers ending in the result register.
// Every multiply in the frame transform, the edge-axis tests and the plane test has its own
// pipeline stage, so the rate is set by the pipeline advancing once per cycle whenever the
// result register is free or being taken. Registers sit at byte address 8*index and must
// only be written while no triangle is in flight.
module triangle_obb_overlap_test #(
   parameter int COORD_BITS     = tobb_pkg::COORD_BITS_DEF,
   parameter int AXIS_FRAC_BITS = tobb_pkg::AXIS_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // corner_a_x, corner_a_y, corner_a_z, corner_b_x .. corner_c_z, then zero pad
   input  logic [((9*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // overlaps, separating_axis[3:0], then zero pad
   output logic [7:0]                        rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tobb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tobb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tobb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   localparam int RX = tobb_pkg::REG_W;
   localparam int AB = AXIS_FRAC_BITS + 2;
   localparam int PW = COORD_BITS + 1;

   logic [RX-1:0] center_ff, axis0_ff, axis1_ff, axis2_ff, half_ff;
   logic [tobb_pkg::TOL_W-1:0] tol_ff;
   logic                       wr_en;
   tobb_pkg::reg_index_type    idx;

   logic                       f_valid, pop;
   logic [9*PW-1:0]            f_data, q_data;
   tobb_pkg::queue_stat_type   q_stat;
   logic                       ovl;
   logic [tobb_pkg::AXIS_CODE_W-1:0] code;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx        = tobb_pkg::reg_index_type'(csr_paddr[tobb_pkg::CSR_ADDR_W-1:3]);

   always_comb begin
      unique case (idx)
         tobb_pkg::REG_CENTER:      csr_prdata = 64'(center_ff);
         tobb_pkg::REG_AXIS_FIRST:  csr_prdata = 64'(axis0_ff);
         tobb_pkg::REG_AXIS_SECOND: csr_prdata = 64'(axis1_ff);
         tobb_pkg::REG_AXIS_THIRD:  csr_prdata = 64'(axis2_ff);
         tobb_pkg::REG_HALF:        csr_prdata = 64'(half_ff);
         tobb_pkg::REG_TOL:         csr_prdata = 64'(tol_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         axis0_ff  <= RX'(1) << AXIS_FRAC_BITS;
         axis1_ff  <= RX'(1) << (AXIS_FRAC_BITS + AB);
         axis2_ff  <= RX'(1) << (AXIS_FRAC_BITS + 2*AB);
         half_ff   <= '0;
         tol_ff    <= '0;
      end else if (wr_en) begin
         case (idx)
            tobb_pkg::REG_CENTER:      center_ff <= csr_pwdata[RX-1:0];
            tobb_pkg::REG_AXIS_FIRST:  axis0_ff  <= csr_pwdata[RX-1:0];
            tobb_pkg::REG_AXIS_SECOND: axis1_ff  <= csr_pwdata[RX-1:0];
            tobb_pkg::REG_AXIS_THIRD:  axis2_ff  <= csr_pwdata[RX-1:0];
            tobb_pkg::REG_HALF:        half_ff   <= csr_pwdata[RX-1:0];
            tobb_pkg::REG_TOL:         tol_ff    <= csr_pwdata[tobb_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   tobb_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_data   (req_tdata[9*COORD_BITS-1:0]),
      .box_center (center_ff),
      .queue_stat (q_stat),
      .out_valid  (f_valid),
      .out_data   (f_data)
   );

   tobb_fifo #(.WIDTH(9*PW), .DEPTH(tobb_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_data (f_data),
      .pop       (pop),
      .pop_data  (q_data),
      .stat      (q_stat)
   );

   tobb_back #(.COORD_BITS(COORD_BITS), .AXIS_FRAC_BITS(AXIS_FRAC_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (!q_stat.empty),
      .in_pop          (pop),
      .in_data         (q_data),
      .axis_first      (axis0_ff),
      .axis_second     (axis1_ff),
      .axis_third      (axis2_ff),
      .half_extents    (half_ff),
      .tolerance       (tol_ff),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .overlaps        (ovl),
      .separating_axis (code)
   );

   assign rsp_tdata = {3'b000, code, ovl};

endmodule

@@ hdl/tobb_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
module tobb_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[4:1] == tobb_pkg::AXIS_NONE)))
      else $error("overlap flag disagrees with axis code");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:1] <= tobb_pkg::AXIS_PLANE) && (rsp_tdata[7:5] == 3'b000))
      else $error("axis code out of range");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word after reset");

endmodule

bind triangle_obb_overlap_test tobb_checker u_tobb_checker (.*);

@@ bench/tb_triangle_obb_overlap_test.sv @@
// Self-checking bench for the triangle versus oriented box overlap test.
module tb_triangle_obb_overlap_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 16;
   localparam int AB = 16;
   localparam int FB = 14;
   localparam int RANDOM_WORDS = 1850;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [tobb_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [tobb_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [tobb_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   triangle_obb_overlap_test DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic overlaps;
      logic [3:0] axis_code;
   } verdict_type;

   // box registers mirrored for prediction
   logic [47:0] center_r, axis_r[3], half_r;
   logic [15:0] tol_r;

   verdict_type expected_verdicts[$];
   int errors = 0;
   int cycles = 0;
   bit idle_enable = 1'b1;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic longint sx(input logic [63:0] v, input int w);
      longint r;
      r = longint'(v << (64 - w));
      return r >>> (64 - w);
   endfunction

   function automatic bit is_lt(input longint a, input longint b, input longint t);
      return a < b - t;
   endfunction

   function automatic bit is_gt(input longint a, input longint b, input longint t);
      return a > b + t;
   endfunction

   function automatic bit interval_clear(input longint p0, input longint p1,
                                         input longint r, input longint t);
      longint mn, mx;
      mn = p0 < p1 ? p0 : p1;
      mx = p0 < p1 ? p1 : p0;
      return is_lt(mx, -r, t) || is_gt(mn, r, t);
   endfunction

   function automatic longint absval(input longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic verdict_type predict_overlap(input logic [143:0] tri_word);
      longint v[3][3], h[3], e[3], n[3], ea[3], eb[3];
      longint t, p, s, d, tmin, tmax, mn, mx;
      int nx, pr, code;
      verdict_type res;
      t = longint'(tol_r);
      code = 0;
      for (int j = 0; j < 3; j++) h[j] = longint'(half_r[j*CB +: CB]);
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++) begin
            s = 0;
            for (int j = 0; j < 3; j++) begin
               p = sx(tri_word[(i*3+j)*CB +: CB], CB) - sx(center_r[j*CB +: CB], CB);
               s += sx(axis_r[k][j*AB +: AB], AB) * p;
            end
            v[i][k] = s >>> FB;
         end
      for (int k = 0; k < 3 && code == 0; k++) begin
         nx = (k + 1) % 3;
         pr = (k + 2) % 3;
         for (int j = 0; j < 3; j++) e[j] = v[nx][j] - v[k][j];
         if (interval_clear(-e[2]*v[k][1] + e[1]*v[k][2], -e[2]*v[pr][1] + e[1]*v[pr][2],
                            absval(e[2])*h[1] + absval(e[1])*h[2], t))
            code = 3*k + 1;
         else if (interval_clear(-e[0]*v[k][2] + e[2]*v[k][0],
                                 -e[0]*v[pr][2] + e[2]*v[pr][0],
                                 absval(e[0])*h[2] + absval(e[2])*h[0], t))
            code = 3*k + 2;
         else if (interval_clear(-e[1]*v[k][0] + e[0]*v[k][1],
                                 -e[1]*v[pr][0] + e[0]*v[pr][1],
                                 absval(e[1])*h[0] + absval(e[0])*h[1], t))
            code = 3*k + 3;
      end
      for (int j = 0; j < 3 && code == 0; j++) begin
         mn = v[0][j];
         mx = v[0][j];
         for (int i = 1; i < 3; i++) begin
            if (v[i][j] < mn) mn = v[i][j];
            if (v[i][j] > mx) mx = v[i][j];
         end
         if (is_gt(mn, h[j], t) || is_lt(mx, -h[j], t)) code = 10 + j;
      end
      if (code == 0) begin
         for (int j = 0; j < 3; j++) begin
            ea[j] = v[1][j] - v[0][j];
            eb[j] = v[2][j] - v[0][j];
         end
         n[0] = ea[1]*eb[2] - ea[2]*eb[1];
         n[1] = ea[2]*eb[0] - ea[0]*eb[2];
         n[2] = ea[0]*eb[1] - ea[1]*eb[0];
         d = -(n[0]*v[0][0] + n[1]*v[0][1] + n[2]*v[0][2]);
         tmin = d;
         tmax = d;
         for (int j = 0; j < 3; j++)
            if (is_gt(n[j], 0, t)) begin
               tmin -= n[j]*h[j];
               tmax += n[j]*h[j];
            end else begin
               tmin += n[j]*h[j];
               tmax -= n[j]*h[j];
            end
         if (is_gt(tmin, 0, t) || is_lt(tmax, 0, t)) code = tobb_pkg::AXIS_PLANE;
      end
      res.overlaps = (code == 0);
      res.axis_code = code[3:0];
      return res;
   endfunction

   function automatic bit idle_now();
      return idle_enable && ($urandom_range(99) < 31);
   endfunction

   task automatic write_reg(input tobb_pkg::reg_index_type idx, input logic [47:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= tobb_pkg::CSR_ADDR_W'(8 * int'(idx));
      csr_pwdata <= 64'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         tobb_pkg::REG_CENTER:      center_r = value;
         tobb_pkg::REG_AXIS_FIRST:  axis_r[0] = value;
         tobb_pkg::REG_AXIS_SECOND: axis_r[1] = value;
         tobb_pkg::REG_AXIS_THIRD:  axis_r[2] = value;
         tobb_pkg::REG_HALF:        half_r = value;
         tobb_pkg::REG_TOL:         tol_r = value[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one word sent, with optional check value typed in
   task automatic send_triangle(input logic [143:0] w, input bit fixed, input verdict_type fv);
      verdict_type pv;
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= w;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pv = predict_overlap(w);
      if (fixed && pv != fv) report($sformatf("typed verdict %h vs predictor %h", fv, pv));
      expected_verdicts.push_back(fixed ? fv : pv);
      @(negedge clock);
   endtask

   function automatic logic [143:0] pack_tri(input logic [15:0] c[9]);
      logic [143:0] w;
      for (int i = 0; i < 9; i++) w[i*16 +: 16] = c[i];
      return w;
   endfunction

   function automatic logic [15:0] rnd_coord(input int span);
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'(int'($urandom_range(2*span)) - span);
      endcase
   endfunction

   function automatic logic [47:0] rnd_axes_slot(input int k);
      logic [47:0] r;
      r = '0;
      case ($urandom_range(3))
         0: r = 48'($urandom) | (48'($urandom) << 32);
         1: r[k*16 +: 16] = $urandom_range(1) ? 16'h4000 : 16'hc000;
         default: for (int j = 0; j < 3; j++) r[j*16 +: 16] = 16'(int'($urandom_range(32768)) - 16384);
      endcase
      return r;
   endfunction

   typedef struct {
      logic [15:0] c[9];
      bit fixed;
      verdict_type fv;
   } stim_row_type;

   stim_row_type directed[$];

   always @(posedge clock) begin
      verdict_type got, want;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[0], rsp_tdata[4:1]};
         if (expected_verdicts.size() == 0) report("result word with nothing expected");
         else begin
            want = expected_verdicts.pop_front();
            if (got.overlaps != want.overlaps)
               report($sformatf("overlaps %0b want %0b", got.overlaps, want.overlaps));
            if (got.axis_code != want.axis_code)
               report($sformatf("axis %0d want %0d", got.axis_code, want.axis_code));
         end
         if (rsp_tdata[7:5] != 3'b0) report("pad bits set");
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_tready <= !idle_now();
      end
   end

   initial begin
      logic [15:0] c[9];
      stim_row_type row;
      int span;
      center_r = '0;
      axis_r[0] = 48'd16384;
      axis_r[1] = 48'd1073741824;
      axis_r[2] = 48'd70368744177664;
      half_r = '0;
      tol_r = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset: zero box, degenerate triangle at origin touches it
      row.fixed = 1;
      row.fv = '{1'b1, tobb_pkg::AXIS_NONE};
      foreach (c[i]) row.c[i] = 16'h0000;
      directed.push_back(row);
      // all at extremes: degenerate point far out, face x separates
      foreach (c[i]) row.c[i] = 16'h7fff;
      row.fv = '{1'b0, 4'd10};
      directed.push_back(row);
      foreach (c[i]) row.c[i] = 16'h8000;
      directed.push_back(row);
      row.fixed = 0;
      for (int k = 0; k < 22; k++) begin
         foreach (c[i]) row.c[i] = rnd_coord(k < 11 ? 50 : 30000);
         if (k % 4 == 0) foreach (c[i]) row.c[i] = $urandom_range(1) ? 16'h7fff : 16'h8000;
         directed.push_back(row);
      end
      foreach (directed[r]) send_triangle(pack_tri(directed[r].c), directed[r].fixed,
                                          directed[r].fv);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         write_reg(tobb_pkg::REG_CENTER, ph == 1 ? 48'hffff_ffff_ffff :
                   ph == 2 ? 48'h8000_8000_8000 : {16'($urandom_range(200)),
                   16'($urandom_range(200)), 16'($urandom_range(200))});
         write_reg(tobb_pkg::REG_AXIS_FIRST, ph == 0 ? 48'h4000 : rnd_axes_slot(0));
         write_reg(tobb_pkg::REG_AXIS_SECOND, ph == 0 ? 48'h4000_0000 : rnd_axes_slot(1));
         write_reg(tobb_pkg::REG_AXIS_THIRD, ph == 0 ? 48'h4000_0000_0000 : rnd_axes_slot(2));
         write_reg(tobb_pkg::REG_HALF, ph == 3 ? 48'hffff_ffff_ffff : ph == 4 ? 48'h0 :
                   {16'($urandom_range(300)), 16'($urandom_range(300)),
                    16'($urandom_range(300))});
         write_reg(tobb_pkg::REG_TOL, ph == 5 ? 16'hffff : ph == 6 ? 16'h0 :
                   16'($urandom_range(40)));
         idle_enable = (ph != 4);
         span = (ph % 2) ? 400 : 30000;
         for (int n = 0; n < RANDOM_WORDS / 8; n++) begin
            foreach (c[i]) c[i] = rnd_coord(span);
            send_triangle(pack_tri(c), 0, '0);
         end
         wait_drained();
      end
      idle_enable = 1'b1;

      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end
endmodule
